>>> design/multi_date_pixel_composite_select_macros.svh
// Assertion macros shared by the compositing design.
`ifndef MULTI_DATE_PIXEL_COMPOSITE_SELECT_MACROS_SVH
`define MULTI_DATE_PIXEL_COMPOSITE_SELECT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MDPCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define MDPCS_ASSERT_IMPL(lbl, pre, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MDPCS_ASSERT_NEXT(lbl, pre, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mdpcs_pkg.sv
// Types and constants of the multi-date pixel compositing block.
`default_nettype none

package mdpcs_pkg;

  localparam int unsigned ValW   = 16;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned WcW    = 8;
  localparam int unsigned ThrW   = 10;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic signed [ValW-1:0] NdviFill = -16'sd32767;
  localparam logic [ThrW-1:0] WaterThrReset = 10'd1000;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCompositeMode = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWaterThreshold = 1'd1;

  // Composite modes
  localparam logic ModeMaxNdvi = 1'b0;
  localparam logic ModeMinBlue = 1'b1;

  // Pixel status codes
  localparam logic [StatW-1:0] StatusValid = 2'd0;
  localparam logic [StatW-1:0] StatusFill  = 2'd1;
  localparam logic [StatW-1:0] StatusWater = 2'd2;

  // One observation as held in the input register
  typedef struct packed {
    logic [ValW-1:0] ndvi;
    logic [ValW-1:0] blue;
    logic [ValW-1:0] red;
    logic [WcW-1:0]  water_count;
    logic            first_obs;
    logic            last_obs;
  } obs_t;

endpackage

`default_nettype wire

>>> design/multi_date_pixel_composite_select.sv
// Top level of the multi-date pixel compositing block (max NDVI / min blue).
//
//  Channel   Dir  Signals                    Contents
//  s_axis    in   tvalid/tready/tdata/tuser  one date: ndvi, blue, red, water_count;
//                 tlast                      tuser = first_obs, tlast = last_obs
//  m_axis    out  tvalid/tready/tdata/tuser  tdata = chosen_index, tuser = pixel_status
//  cfg       in   we/index/wdata             composite_mode, water_threshold
//
// One request per cycle sustained while the input register does not stall: an input
// register feeds one compare/select level that updates the running winners and
// loads the result register. Result valid is registered: an accepted last date
// passes the input register and then loads the result register.
// Reset clears the running winners, the date counter and both handshake stages;
// composite_mode resets to max NDVI and water_threshold to 1000.
// The input register stalls only when it holds a last date and the result
// register is still occupied; dates that give no result always advance.
`default_nettype none

`include "multi_date_pixel_composite_select_macros.svh"

module multi_date_pixel_composite_select #(
  parameter int unsigned MAX_DATES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic [mdpcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mdpcs_pkg::ThrW-1:0]    cfg_wdata_i,
  // observation stream
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [55:0] s_axis_tdata_i,   // ndvi[15:0] blue[31:16] red[47:32] water_count[55:48]
  input  wire logic        s_axis_tuser_i,   // first_obs[0]
  input  wire logic        s_axis_tlast_i,   // last_obs
  // result stream
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [7:0]  m_axis_tdata_o,   // chosen_index[3:0], zero fill [7:4]
  output      logic [1:0]  m_axis_tuser_o    // pixel_status[1:0]
);

  localparam int unsigned IdxW = mdpcs_pkg::IdxW;
  localparam int unsigned ValW = mdpcs_pkg::ValW;
  // index saturates at the lesser of MAX_DATES-1 and 15
  localparam int unsigned IdxLimit = (MAX_DATES < 16) ? MAX_DATES : 16;
  localparam logic [IdxW-1:0] IdxMax = IdxW'(IdxLimit - 1);

  // ---------------------------------------------------------------- config
  logic                       mode_q;
  logic [mdpcs_pkg::ThrW-1:0] water_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mdpcs_pkg::ModeMaxNdvi;
      water_thr_q <= mdpcs_pkg::WaterThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mdpcs_pkg::RegCompositeMode:  mode_q      <= cfg_wdata_i[0];
        mdpcs_pkg::RegWaterThreshold: water_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- input register
  logic            in_valid_q;
  mdpcs_pkg::obs_t in_q;
  logic            in_adv;
  logic            out_valid_q;

  // a date without a result never waits for the output side
  assign in_adv          = in_valid_q && (!in_q.last_obs || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q.ndvi        <= s_axis_tdata_i[15:0];
      in_q.blue        <= s_axis_tdata_i[31:16];
      in_q.red         <= s_axis_tdata_i[47:32];
      in_q.water_count <= s_axis_tdata_i[55:48];
      in_q.first_obs   <= s_axis_tuser_i;
      in_q.last_obs    <= s_axis_tlast_i;
    end
  end

  // --------------------------------------------------------- running winners
  logic [IdxW-1:0]        obs_cnt_q,  obs_cnt_d;
  logic [IdxW-1:0]        ndvi_idx_q, ndvi_idx_d;
  logic signed [ValW-1:0] ndvi_q,     ndvi_d;
  logic [IdxW-1:0]        blue_idx_q, blue_idx_d;
  logic signed [ValW-1:0] blue_q,     blue_d;
  logic signed [ValW-1:0] red_q,      red_d;

  logic signed [ValW-1:0] n_s, b_s, r_s;
  logic                   pix_start;
  logic [IdxW-1:0]        cur_idx;
  logic                   blue_win;

  assign n_s = in_q.ndvi;
  assign b_s = in_q.blue;
  assign r_s = in_q.red;

  // a pixel opens on first_obs or after a last date / reset
  assign pix_start = in_q.first_obs || (obs_cnt_q == '0);
  assign cur_idx   = pix_start ? '0 : obs_cnt_q;

  // blue rules, all against the previous winner
  assign blue_win = (blue_q < 0 && b_s >= 0)
                 || (blue_q >= 0 && b_s >= 0 && r_s >= 0 && b_s < blue_q)
                 || (red_q < 0 && r_s < 0 && r_s > red_q);

  always_comb begin
    ndvi_idx_d = ndvi_idx_q;
    ndvi_d     = ndvi_q;
    blue_idx_d = blue_idx_q;
    blue_d     = blue_q;
    red_d      = red_q;
    if (pix_start) begin
      ndvi_idx_d = '0;
      ndvi_d     = n_s;
      blue_idx_d = '0;
      blue_d     = b_s;
      red_d      = r_s;
    end else begin
      if (n_s > ndvi_q) begin
        ndvi_idx_d = cur_idx;
        ndvi_d     = n_s;
      end
      if (blue_win) begin
        blue_idx_d = cur_idx;
        blue_d     = b_s;
        red_d      = r_s;
      end
    end
    // hold the index at its ceiling once reached; restart after the last date
    if (in_q.last_obs) begin
      obs_cnt_d = '0;
    end else if (cur_idx == IdxMax) begin
      obs_cnt_d = IdxMax;
    end else begin
      obs_cnt_d = cur_idx + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_cnt_q  <= '0;
      ndvi_idx_q <= '0;
      ndvi_q     <= '0;
      blue_idx_q <= '0;
      blue_q     <= '0;
      red_q      <= '0;
    end else if (in_adv) begin
      obs_cnt_q  <= obs_cnt_d;
      ndvi_idx_q <= ndvi_idx_d;
      ndvi_q     <= ndvi_d;
      blue_idx_q <= blue_idx_d;
      blue_q     <= blue_d;
      red_q      <= red_d;
    end
  end

  // ------------------------------------------------------------ result logic
  logic [IdxW-1:0]             res_idx;
  logic [mdpcs_pkg::StatW-1:0] res_stat;
  logic                        res_fill;
  logic                        res_water;

  assign res_fill  = (mode_q == mdpcs_pkg::ModeMinBlue) ? (blue_d < 0)
                                                        : (ndvi_d == mdpcs_pkg::NdviFill);
  assign res_water = {2'b00, in_q.water_count} >= water_thr_q;

  always_comb begin
    priority if (res_fill) begin
      res_stat = mdpcs_pkg::StatusFill;
      res_idx  = '0;
    end else if (res_water) begin
      res_stat = mdpcs_pkg::StatusWater;
      res_idx  = '0;
    end else begin
      res_stat = mdpcs_pkg::StatusValid;
      res_idx  = (mode_q == mdpcs_pkg::ModeMinBlue) ? blue_idx_d : ndvi_idx_d;
    end
  end

  // --------------------------------------------------------- result register
  logic                        out_load;
  logic [IdxW-1:0]             out_idx_q;
  logic [mdpcs_pkg::StatW-1:0] out_stat_q;

  assign out_load = in_adv && in_q.last_obs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= res_idx;
      out_stat_q <= res_stat;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(8 - IdxW){1'b0}}, out_idx_q};
  assign m_axis_tuser_o  = out_stat_q;

  // -------------------------------------------------------------- assertions
  `MDPCS_ASSERT(a_cnt_ceiling, obs_cnt_q <= IdxMax, "date counter beyond its ceiling")
  `MDPCS_ASSERT_IMPL(a_idx_zero_on_bad, m_axis_tvalid_o && (m_axis_tuser_o != mdpcs_pkg::StatusValid), m_axis_tdata_o == '0, "nonzero index with fill or water status")
  `MDPCS_ASSERT_IMPL(a_stall_cause, in_valid_q && !in_adv, in_q.last_obs && out_valid_q && !m_axis_tready_i, "input register stalled without a full result register")
  `MDPCS_ASSERT_NEXT(a_load_shows, out_load, m_axis_tvalid_o && (obs_cnt_q == '0), "last date did not give a result or restart the pixel")

endmodule

`default_nettype wire

>>> sim/multi_date_pixel_composite_select_test.sv
// Self-checking testbench for the multi-date pixel compositing block.
`timescale 1ns / 1ps

module multi_date_pixel_composite_select_test;
  import mdpcs_pkg::*;

  // Keep MAX_DATES at its default so the date index saturates at 15.
  localparam int MaxDates   = 16;
  localparam int IdxSat     = ((MaxDates < 16) ? MaxDates : 16) - 1;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  // Result valid follows the accept through the input and result registers; leave a margin before touching registers.
  localparam int DrainCycles = 6;

  // One date of one pixel as the sender sees it.
  typedef struct {
    logic signed [ValW-1:0] ndvi;
    logic signed [ValW-1:0] blue;
    logic signed [ValW-1:0] red;
    logic [WcW-1:0]         water_count;
    logic                   first_obs;
    logic                   last_obs;
  } obs_item_t;

  // One pixel decision as the result stream carries it.
  typedef struct {
    logic [IdxW-1:0]  chosen_index;
    logic [StatW-1:0] status;
  } pixel_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [ThrW-1:0]   cfg_wdata_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [55:0]       s_axis_tdata_i = '0;   // ndvi[15:0] blue[31:16] red[47:32] water_count[55:48]
  logic              s_axis_tuser_i = 1'b0; // first_obs[0]
  logic              s_axis_tlast_i = 1'b0; // last_obs
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [7:0]        m_axis_tdata_o;        // chosen_index[3:0], zero fill [7:4]
  logic [1:0]        m_axis_tuser_o;        // pixel_status[1:0]

  multi_date_pixel_composite_select #(
    .MAX_DATES(MaxDates)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_index_i    (cfg_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Idle rates in percent, changed per phase by the test sequence.
  int send_idle_pct = 35;
  int recv_idle_pct = 83;
  // Cycles left in a forced receiver hold-off; set at a rising edge, counted down below.
  int recv_hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // Decisions still owed by the block, oldest first.
  pixel_result_t pixel_decisions_due[$];

  // Shadow of the block: configuration and the two running winners.
  logic            mode_sel = ModeMaxNdvi;
  logic [ThrW-1:0] water_thr = WaterThrReset;
  logic [IdxW-1:0] next_date = '0;
  logic [IdxW-1:0] ndvi_best_idx = '0;
  logic signed [ValW-1:0] ndvi_best = '0;
  logic [IdxW-1:0] blue_best_idx = '0;
  logic signed [ValW-1:0] blue_best = '0;
  logic signed [ValW-1:0] blue_best_red = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Abort a run that hangs: no handshake may stall this long in a correct design.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("multi_date_pixel_composite_select verification failed");
      $finish;
    end
  end

  // Receiver: hold off for a forced stretch, otherwise accept at the phase's rate.
  always @(negedge clk_i) begin
    if (recv_hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      recv_hold_left <= recv_hold_left - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted decision with the oldest one owed.
  always @(posedge clk_i) begin
    pixel_result_t due;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pixel_decisions_due.size() == 0) begin
        $display("%0t: unexpected decision: index %0d status %0d", $time,
                 m_axis_tdata_o[IdxW-1:0], m_axis_tuser_o);
        mismatches++;
      end else begin
        due = pixel_decisions_due.pop_front();
        if (m_axis_tdata_o[IdxW-1:0] !== due.chosen_index) begin
          $display("%0t: chosen_index expected %0d actual %0d", $time,
                   due.chosen_index, m_axis_tdata_o[IdxW-1:0]);
          mismatches++;
        end
        if (m_axis_tuser_o !== due.status) begin
          $display("%0t: pixel_status expected %0d actual %0d", $time,
                   due.status, m_axis_tuser_o);
          mismatches++;
        end
      end
    end
  end

  // Advance the shadow winners by one accepted date; queue a decision on the last date.
  function automatic void predict_composite(input obs_item_t o);
    logic [IdxW-1:0] idx;
    logic take_blue;
    pixel_result_t r;
    if (o.first_obs || next_date == 0) begin
      // Open a new pixel: this date seeds both winners at index 0.
      idx = '0;
      ndvi_best_idx = '0;
      ndvi_best = o.ndvi;
      blue_best_idx = '0;
      blue_best = o.blue;
      blue_best_red = o.red;
    end else begin
      idx = next_date;
      // Only a strictly larger NDVI displaces the winner, so ties keep the earlier date.
      if (o.ndvi > ndvi_best) begin
        ndvi_best_idx = idx;
        ndvi_best = o.ndvi;
      end
      take_blue = (blue_best < 0 && o.blue >= 0) ||
                  (blue_best >= 0 && o.blue >= 0 && o.red >= 0 && o.blue < blue_best) ||
                  (blue_best_red < 0 && o.red < 0 && o.red > blue_best_red);
      if (take_blue) begin
        blue_best_idx = idx;
        blue_best = o.blue;
        blue_best_red = o.red;
      end
    end
    // Saturate the date index; later dates still compete under the last index.
    next_date = (idx == IdxSat) ? idx : idx + 1'b1;
    if (o.last_obs) begin
      next_date = '0;
      if (mode_sel == ModeMaxNdvi) begin
        r.chosen_index = ndvi_best_idx;
        r.status = (ndvi_best == NdviFill) ? StatusFill : StatusValid;
      end else begin
        r.chosen_index = blue_best_idx;
        r.status = (blue_best < 0) ? StatusFill : StatusValid;
      end
      if (r.status == StatusValid && o.water_count >= water_thr) r.status = StatusWater;
      if (r.status != StatusValid) r.chosen_index = '0;
      pixel_decisions_due.push_back(r);
    end
  endfunction

  // Offer one date and hold it until accepted; called and returning at a falling edge.
  task automatic send_obs(input obs_item_t o);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i = 56'({$urandom, $urandom});
      s_axis_tuser_i = 1'($urandom_range(1));
      s_axis_tlast_i = 1'($urandom_range(1));
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {o.water_count, o.red, o.blue, o.ndvi};
    s_axis_tuser_i = o.first_obs;
    s_axis_tlast_i = o.last_obs;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_composite(o);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic send_date(input int ndvi, input int blue, input int red, input int wc,
                           input bit first, input bit last);
    obs_item_t o;
    o.ndvi = ValW'(ndvi);
    o.blue = ValW'(blue);
    o.red = ValW'(red);
    o.water_count = WcW'(wc);
    o.first_obs = first;
    o.last_obs = last;
    send_obs(o);
  endtask

  // Hold until every owed decision has come back and the pipeline has drained.
  task automatic wait_drained();
    while (pixel_decisions_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write one register while the block is idle, and mirror it in the shadow.
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [ThrW-1:0] value);
    wait_drained();
    cfg_we_i = 1'b1;
    cfg_index_i = index;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_wdata_i = ThrW'($urandom);
    if (index == RegCompositeMode) mode_sel = value[0];
    else water_thr = value;
  endtask

  // Bias values toward the boundaries, ties and the fill code.
  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return NdviFill;
      3: return 16'sd0;
      4: return -16'sd1;
      5: return ValW'($urandom_range(20));
      6: return -ValW'($urandom_range(1, 500));
      default: return ValW'($urandom);
    endcase
  endfunction

  // Send random pixels: mostly well-formed runs, some broken or restarted ones.
  task automatic send_random_pixels(input int n_items);
    int sent;
    int len;
    obs_item_t o;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(14) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
      for (int d = 0; d < len; d++) begin
        o.ndvi = pick_value();
        o.blue = pick_value();
        o.red = pick_value();
        o.water_count = WcW'($urandom_range(255));
        // Drop the opening mark now and then, and restart mid-pixel rarely.
        o.first_obs = (d == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
        // Leave a pixel unterminated now and then so it runs into the next one.
        o.last_obs = (d == len - 1) ? ($urandom_range(14) != 0) : 1'b0;
        send_obs(o);
        sent++;
      end
    end
  endtask

  // After reset: defaults hold, and a date without the opening mark still opens a pixel.
  task automatic test_reset_defaults();
    send_date(100, 10, 10, 0, 1'b0, 1'b0);
    send_date(200, 20, 20, 255, 1'b0, 1'b1);
  endtask

  // Maximum NDVI: extremes, a tie that keeps the earlier date, and the fill value.
  task automatic test_max_ndvi();
    write_reg(RegCompositeMode, ThrW'(ModeMaxNdvi));
    send_date(-32768, 0, 0, 0, 1'b1, 1'b0);
    send_date(32767, 0, 0, 0, 1'b0, 1'b0);
    send_date(32767, 0, 0, 0, 1'b0, 1'b0);
    send_date(0, 0, 0, 0, 1'b0, 1'b1);
    // Single date that is fill.
    send_date(-32767, 5, 5, 255, 1'b1, 1'b1);
    // A fill first date displaced by a later larger one.
    send_date(-32767, 0, 0, 0, 1'b1, 1'b0);
    send_date(-32768, 0, 0, 0, 1'b0, 1'b0);
    send_date(-32766, 0, 0, 0, 1'b0, 1'b1);
  endtask

  // Water threshold: on the boundary, at zero, and fill taking precedence over water.
  task automatic test_water_threshold();
    write_reg(RegWaterThreshold, 10'd255);
    send_date(10, 0, 0, 255, 1'b1, 1'b1);
    send_date(10, 0, 0, 254, 1'b1, 1'b1);
    write_reg(RegWaterThreshold, 10'd0);
    send_date(-32767, 0, 0, 0, 1'b1, 1'b1);
    send_date(10, 0, 0, 0, 1'b1, 1'b1);
  endtask

  // Minimum blue: each replacement rule, a rule blocked by invalid red, and blue fill.
  task automatic test_min_blue();
    write_reg(RegCompositeMode, ThrW'(ModeMinBlue));
    write_reg(RegWaterThreshold, 10'd1023);
    send_date(0, -5, 10, 0, 1'b1, 1'b0);
    send_date(0, 300, 10, 0, 1'b0, 1'b0);   // valid blue beats negative
    send_date(0, 100, -1, 0, 1'b0, 1'b0);   // smaller blue but red invalid
    send_date(0, 50, 7, 255, 1'b0, 1'b1);   // smaller blue with valid red
    send_date(0, -1, -300, 0, 1'b1, 1'b0);
    send_date(0, -2, -100, 0, 1'b0, 1'b0);  // larger negative red
    send_date(0, -3, -32768, 0, 1'b0, 1'b1);
    send_date(0, 32767, -32768, 255, 1'b1, 1'b1);
  endtask

  // More dates than the index holds: the index sticks at its top value.
  task automatic test_date_saturation();
    write_reg(RegCompositeMode, ThrW'(ModeMaxNdvi));
    for (int d = 0; d < 18; d++) begin
      send_date(d * 100, 0, 0, 0, d == 0, d == 17);
    end
  endtask

  // One random phase: sweep the registers through extremes and random settings.
  task automatic test_random_phase(input int n_items, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < 4; k++) begin
      write_reg(RegCompositeMode, ThrW'(k[0]));
      case (k)
        0: write_reg(RegWaterThreshold, 10'd0);
        1: write_reg(RegWaterThreshold, 10'd1023);
        2: write_reg(RegWaterThreshold, ThrW'($urandom_range(255)));
        default: write_reg(RegWaterThreshold, ThrW'($urandom_range(1023)));
      endcase
      send_random_pixels(n_items / 4);
    end
  endtask

  // Hold the receiver off while the sender keeps pushing single-date pixels,
  // so the result stage fills and the input stalls.
  task automatic test_backpressure();
    obs_item_t o;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    recv_hold_left = HoldCycles;
    @(negedge clk_i);
    for (int i = 0; i < 30; i++) begin
      o.ndvi = pick_value();
      o.blue = pick_value();
      o.red = pick_value();
      o.water_count = WcW'($urandom_range(255));
      o.first_obs = 1'b1;
      o.last_obs = 1'b1;
      send_obs(o);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_max_ndvi();
    test_water_threshold();
    test_min_blue();
    test_date_saturation();

    test_random_phase(240, 35, 83);
    test_random_phase(240, 83, 35);
    test_random_phase(240, 0, 0);
    test_backpressure();

    // Let the last decisions drain before judging the run.
    wait_drained();
    if (mismatches == 0) begin
      $display("multi_date_pixel_composite_select verification clean");
    end else begin
      $display("multi_date_pixel_composite_select verification failed");
    end
    $finish;
  end

endmodule
